/* design/dd2_pkg.sv */
// dd2_pkg: shared types, constants and helpers of the duration to double-double block
// used by dd2_stream_if, dd2_fadd and duration_to_double_double_top
`default_nettype none

package dd2_pkg;

    typedef logic [63:0] t_dbl;

    localparam int DD2_W     = 64;
    localparam int DD2_LAT   = 4;            // stages of one binary64 adder
    localparam int DD2_FE    = 7;            // stages of the integer split and scaling front end
    localparam int DD2_NLVL  = 18;           // dependent adder levels after the front end
    localparam int DD2_NSTG  = DD2_FE + DD2_LAT * DD2_NLVL;
    localparam int DD2_BIAS  = 1023;

    // 1e-18 = 0x1.2725dd1d243acp-60, significand with hidden bit
    localparam logic [52:0] DD2_ATTO_MANT = 53'h12725DD1D243AC;
    // biased exponent of a product whose significand lands in [2^84, 2^85)
    localparam int DD2_ATTO_BEXP = DD2_BIAS - 60;

    // leading zeros of a 56-bit word, 56 when the word is zero
    function automatic logic [5:0] lzc56(input logic [55:0] x);
        logic [5:0] n;
        n = 6'd56;
        for (int i = 0; i < 56; i++) begin
            if (x[i]) begin
                n = 6'(55 - i);
            end
        end
        return n;
    endfunction

    // sign flip turns an add into a subtract
    function automatic t_dbl neg(input t_dbl x);
        return {~x[63], x[62:0]};
    endfunction

endpackage

`default_nettype wire

/* design/dd2_stream_if.sv */
// dd2_stream_if: valid/ready channels of the duration to double-double block
// depends on dd2_pkg
`default_nettype none

interface dd2_in_if
    import dd2_pkg::*;
();
    logic               valid;
    logic               ready;
    logic signed [63:0] seconds;
    logic signed [63:0] attoseconds;

    modport source(output valid, output seconds, output attoseconds, input ready);
    modport sink(input valid, input seconds, input attoseconds, output ready);
endinterface

interface dd2_out_if
    import dd2_pkg::*;
();
    logic valid;
    logic ready;
    t_dbl high_part;
    t_dbl low_part;

    modport source(output valid, output high_part, output low_part, input ready);
    modport sink(input valid, input high_part, input low_part, output ready);
endinterface

`default_nettype wire

/* design/dd2_fadd.sv */
// dd2_fadd: four-stage binary64 adder, round to nearest even, finite operands
// carries a side payload through its stages; depends on dd2_pkg
`default_nettype none

module dd2_fadd
    import dd2_pkg::*;
#(
    parameter int PW = DD2_W
) (
    input  wire logic               i_clk,
    input  wire logic [DD2_LAT-1:0] i_en,
    input  wire t_dbl               i_a,
    input  wire t_dbl               i_b,
    input  wire logic [PW-1:0]      i_pass,
    output t_dbl                    o_sum,
    output logic [PW-1:0]           o_pass
);

    // stage 1: order by magnitude and align
    logic        n_a_ge;
    t_dbl        n_big;
    t_dbl        n_sml;
    logic [10:0] n_d;
    logic [55:0] n_ext;
    logic [55:0] n_sh;
    logic        n_lost;

    logic        r1_sgn, r1_sub, r1_zsg;
    logic [10:0] r1_exp;
    logic [55:0] r1_mb, r1_ms;
    logic [PW-1:0] r1_pass;

    always_comb begin
        n_a_ge = i_a[62:0] >= i_b[62:0];
        n_big  = n_a_ge ? i_a : i_b;
        n_sml  = n_a_ge ? i_b : i_a;
        n_d    = n_big[62:52] - n_sml[62:52];
        n_ext  = {(n_sml[62:52] != 11'd0), n_sml[51:0], 3'b000};
        if (n_d > 11'd55) begin
            n_sh   = '0;
            n_lost = |n_ext;
        end else begin
            n_sh   = n_ext >> n_d[5:0];
            n_lost = |(n_ext & ~({56{1'b1}} << n_d[5:0]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_sgn  <= n_big[63];
            r1_sub  <= n_big[63] ^ n_sml[63];
            r1_zsg  <= i_a[63] & i_b[63];
            r1_exp  <= n_big[62:52];
            r1_mb   <= {(n_big[62:52] != 11'd0), n_big[51:0], 3'b000};
            r1_ms   <= {n_sh[55:1], n_sh[0] | n_lost};
            r1_pass <= i_pass;
        end
    end

    // stage 2: significand add or subtract
    logic        r2_sgn, r2_zsg;
    logic [10:0] r2_exp;
    logic [56:0] r2_sum;
    logic [PW-1:0] r2_pass;

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r2_sgn  <= r1_sgn;
            r2_zsg  <= r1_zsg;
            r2_exp  <= r1_exp;
            r2_sum  <= r1_sub ? ({1'b0, r1_mb} - {1'b0, r1_ms})
                              : ({1'b0, r1_mb} + {1'b0, r1_ms});
            r2_pass <= r1_pass;
        end
    end

    // stage 3: leading zero count
    logic        r3_sgn, r3_zsg;
    logic [10:0] r3_exp;
    logic [56:0] r3_sum;
    logic [5:0]  r3_lz;
    logic [PW-1:0] r3_pass;

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r3_sgn  <= r2_sgn;
            r3_zsg  <= r2_zsg;
            r3_exp  <= r2_exp;
            r3_sum  <= r2_sum;
            r3_lz   <= lzc56(r2_sum[55:0]);
            r3_pass <= r2_pass;
        end
    end

    // stage 4: normalize and round
    logic [55:0] n_norm;
    logic [52:0] n_mant;
    logic        n_g, n_st, n_up;
    logic [53:0] n_m54;
    logic [11:0] n_e;
    t_dbl        n_res;

    always_comb begin
        n_norm = r3_sum[55:0] << r3_lz;
        if (r3_sum[56]) begin
            n_mant = r3_sum[56:4];
            n_g    = r3_sum[3];
            n_st   = |r3_sum[2:0];
            n_e    = {1'b0, r3_exp} + 12'd1;
        end else begin
            n_mant = n_norm[55:3];
            n_g    = n_norm[2];
            n_st   = |n_norm[1:0];
            n_e    = {1'b0, r3_exp} - {6'd0, r3_lz};
        end
        n_up  = n_g & (n_st | n_mant[0]);
        n_m54 = {1'b0, n_mant} + {53'd0, n_up};
        n_e   = n_e + {11'd0, n_m54[53]};
        if (r3_sum == 57'd0) begin
            n_res = {r3_zsg, 63'd0};
        end else begin
            n_res = {r3_sgn, n_e[10:0], n_m54[51:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            o_sum  <= n_res;
            o_pass <= r3_pass;
        end
    end

endmodule

`default_nettype wire

/* design/duration_to_double_double_top.sv */
// duration_to_double_double_top: seconds plus attoseconds to a binary64 double-double
// depends on dd2_pkg, dd2_stream_if and dd2_fadd
//
// Accepts one transaction per cycle while i_in.ready is high and returns one result per
// transaction, in order. The pipeline has 79 register stages: a 7-stage front end
// (integer split, magnitude, leading zero count, normalize, two partial products,
// product sum, rounding) followed by 18 dependent binary64 additions, each through a
// 4-stage adder. Every stage holds its own valid bit and moves whenever the stage after
// it is free, so a result waiting at the output does not block new transactions while
// earlier stages have room.
`default_nettype none

module duration_to_double_double_top
    import dd2_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    dd2_in_if.sink     i_in,
    dd2_out_if.source  o_out
);

    // stage valid bits and stage enables
    logic [DD2_NSTG-1:0] r_vld;
    logic [DD2_NSTG:0]   w_en;
    logic [DD2_NSTG-1:0] n_vld;

    assign w_en[DD2_NSTG] = o_out.ready;
    for (genvar k = 0; k < DD2_NSTG; k++) begin : g_en
        assign w_en[k] = ~r_vld[k] | w_en[k+1];
    end

    assign n_vld = {r_vld[DD2_NSTG-2:0], i_in.valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < DD2_NSTG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    assign i_in.ready  = w_en[0];
    assign o_out.valid = r_vld[DD2_NSTG-1];

    // front end, lanes: 0 seconds upper, 1 seconds lower, 2 atto upper, 3 atto lower
    logic [3:0][32:0] r_f1_v;
    logic [3:0][32:0] r_f2_mag, r_f3_mag;
    logic [3:0]       r_f2_sg, r_f3_sg;
    logic [3:0][5:0]  r_f3_lz;

    // split: lower is the signed low word, upper absorbs its borrow
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_f1_v[0] <= {i_in.seconds[63], i_in.seconds[63:32]}
                         + {32'd0, i_in.seconds[31]};
            r_f1_v[1] <= {i_in.seconds[31], i_in.seconds[31:0]};
            r_f1_v[2] <= {i_in.attoseconds[63], i_in.attoseconds[63:32]}
                         + {32'd0, i_in.attoseconds[31]};
            r_f1_v[3] <= {i_in.attoseconds[31], i_in.attoseconds[31:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 4; j++) begin
            if (w_en[1]) begin
                r_f2_sg[j]  <= r_f1_v[j][32];
                r_f2_mag[j] <= r_f1_v[j][32] ? (~r_f1_v[j] + 33'd1) : r_f1_v[j];
            end
            if (w_en[2]) begin
                r_f3_sg[j]  <= r_f2_sg[j];
                r_f3_mag[j] <= r_f2_mag[j];
                r_f3_lz[j]  <= lzc56({23'd0, r_f2_mag[j]});
            end
        end
    end

    // normalize: seconds halves become doubles here, atto halves go on to the multiplier
    logic [3:0][55:0] n_f4_norm;
    logic [3:0][5:0]  n_f4_p;
    t_dbl             r_f4_sd [2];
    t_dbl             r_f5_sd [2];
    t_dbl             r_f6_sd [2];
    t_dbl             r_f7_sd [2];
    logic [1:0][32:0] r_f4_m;
    logic [1:0][5:0]  r_f4_p, r_f5_p, r_f6_p;
    logic [1:0]       r_f4_sg, r_f5_sg, r_f6_sg;
    logic [1:0]       r_f4_z, r_f5_z, r_f6_z;

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            n_f4_norm[j] = {23'd0, r_f3_mag[j]} << r_f3_lz[j];
            n_f4_p[j]    = 6'd55 - r_f3_lz[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            // upper half carries the 2^32 scale in its exponent
            r_f4_sd[0] <= (r_f3_mag[0] == 33'd0) ? '0 :
                          {r_f3_sg[0], 11'(DD2_BIAS + 32 + int'(n_f4_p[0])),
                           n_f4_norm[0][54:3]};
            r_f4_sd[1] <= (r_f3_mag[1] == 33'd0) ? '0 :
                          {r_f3_sg[1], 11'(DD2_BIAS + int'(n_f4_p[1])),
                           n_f4_norm[1][54:3]};
            for (int j = 0; j < 2; j++) begin
                r_f4_m[j]  <= n_f4_norm[j+2][55:23];
                r_f4_p[j]  <= n_f4_p[j+2];
                r_f4_sg[j] <= r_f3_sg[j+2];
                r_f4_z[j]  <= (r_f3_mag[j+2] == 33'd0);
            end
        end
    end

    // atto scaling: 33 x 53 bit product as two partial products, then summed, then rounded
    logic [1:0][59:0] r_f5_hi;
    logic [1:0][58:0] r_f5_lo;
    logic [1:0][85:0] r_f6_prod;
    t_dbl             r_f7_ad [2];

    logic [1:0]       n_f7_top, n_f7_g, n_f7_st, n_f7_up;
    logic [1:0][52:0] n_f7_mant;
    logic [1:0][53:0] n_f7_m54;
    logic [1:0][11:0] n_f7_be;

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 2; j++) begin
            if (w_en[4]) begin
                r_f5_hi[j] <= {27'd0, r_f4_m[j]} * {33'd0, DD2_ATTO_MANT[52:26]};
                r_f5_lo[j] <= {26'd0, r_f4_m[j]} * {33'd0, DD2_ATTO_MANT[25:0]};
                r_f5_p[j]  <= r_f4_p[j];
                r_f5_sg[j] <= r_f4_sg[j];
                r_f5_z[j]  <= r_f4_z[j];
                r_f5_sd[j] <= r_f4_sd[j];
            end
            if (w_en[5]) begin
                r_f6_prod[j] <= {r_f5_hi[j], 26'd0} + {27'd0, r_f5_lo[j]};
                r_f6_p[j]    <= r_f5_p[j];
                r_f6_sg[j]   <= r_f5_sg[j];
                r_f6_z[j]    <= r_f5_z[j];
                r_f6_sd[j]   <= r_f5_sd[j];
            end
        end
    end

    always_comb begin
        for (int j = 0; j < 2; j++) begin
            n_f7_top[j] = r_f6_prod[j][85];
            if (n_f7_top[j]) begin
                n_f7_mant[j] = r_f6_prod[j][85:33];
                n_f7_g[j]    = r_f6_prod[j][32];
                n_f7_st[j]   = |r_f6_prod[j][31:0];
            end else begin
                n_f7_mant[j] = r_f6_prod[j][84:32];
                n_f7_g[j]    = r_f6_prod[j][31];
                n_f7_st[j]   = |r_f6_prod[j][30:0];
            end
            n_f7_up[j]  = n_f7_g[j] & (n_f7_st[j] | n_f7_mant[j][0]);
            n_f7_m54[j] = {1'b0, n_f7_mant[j]} + {53'd0, n_f7_up[j]};
            // upper half again carries 2^32
            n_f7_be[j]  = 12'(DD2_ATTO_BEXP + ((j == 0) ? 32 : 0) + int'(r_f6_p[j])
                              + int'(n_f7_top[j]) + int'(n_f7_m54[j][53]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            for (int j = 0; j < 2; j++) begin
                r_f7_sd[j] <= r_f6_sd[j];
                r_f7_ad[j] <= r_f6_z[j] ? '0 :
                              {r_f6_sg[j], n_f7_be[j][10:0], n_f7_m54[j][51:0]};
            end
        end
    end

    // two-sum groups: group 0 joins the halves of each input, group 1 adds the
    // leading words (lane 0) and the trailing words (lane 1) of the two pairs
    t_dbl w_ta [2][2];
    t_dbl w_tb [2][2];
    t_dbl w_th [2][2];
    t_dbl w_tl [2][2];

    assign w_ta[0][0] = r_f7_sd[0];
    assign w_tb[0][0] = r_f7_sd[1];
    assign w_ta[0][1] = r_f7_ad[0];
    assign w_tb[0][1] = r_f7_ad[1];
    assign w_ta[1][0] = w_th[0][0];
    assign w_tb[1][0] = w_th[0][1];
    assign w_ta[1][1] = w_tl[0][0];
    assign w_tb[1][1] = w_tl[0][1];

    for (genvar g = 0; g < 2; g++) begin : g_ts
        for (genvar j = 0; j < 2; j++) begin : g_lane
            localparam int B = DD2_FE + DD2_LAT * 5 * g;

            t_dbl         s1, bv, av, ea, eb;
            logic [127:0] p1;
            logic [191:0] p2;
            logic [255:0] p3;
            logic [31:0]  p4a, p4b;

            // s = a + b
            dd2_fadd #(.PW(128)) u_l1 (
                .i_clk(i_clk), .i_en(w_en[B +: DD2_LAT]),
                .i_a(w_ta[g][j]), .i_b(w_tb[g][j]), .i_pass({w_ta[g][j], w_tb[g][j]}),
                .o_sum(s1), .o_pass(p1)
            );
            // bv = s - a
            dd2_fadd #(.PW(192)) u_l2 (
                .i_clk(i_clk), .i_en(w_en[B + DD2_LAT +: DD2_LAT]),
                .i_a(s1), .i_b(neg(p1[127:64])), .i_pass({s1, p1}),
                .o_sum(bv), .o_pass(p2)
            );
            // av = s - bv
            dd2_fadd #(.PW(256)) u_l3 (
                .i_clk(i_clk), .i_en(w_en[B + 2*DD2_LAT +: DD2_LAT]),
                .i_a(p2[191:128]), .i_b(neg(bv)), .i_pass({p2, bv}),
                .o_sum(av), .o_pass(p3)
            );
            // ea = a - av and eb = b - bv; the leading sum rides split across both
            dd2_fadd #(.PW(32)) u_l4a (
                .i_clk(i_clk), .i_en(w_en[B + 3*DD2_LAT +: DD2_LAT]),
                .i_a(p3[191:128]), .i_b(neg(av)), .i_pass(p3[255:224]),
                .o_sum(ea), .o_pass(p4a)
            );
            dd2_fadd #(.PW(32)) u_l4b (
                .i_clk(i_clk), .i_en(w_en[B + 3*DD2_LAT +: DD2_LAT]),
                .i_a(p3[127:64]), .i_b(neg(p3[63:0])), .i_pass(p3[223:192]),
                .o_sum(eb), .o_pass(p4b)
            );
            // error = ea + eb
            dd2_fadd #(.PW(64)) u_l5 (
                .i_clk(i_clk), .i_en(w_en[B + 4*DD2_LAT +: DD2_LAT]),
                .i_a(ea), .i_b(eb), .i_pass({p4a, p4b}),
                .o_sum(w_tl[g][j]), .o_pass(w_th[g][j])
            );
        end
    end

    // renormalization: two quick-two-sums with the trailing terms folded in
    localparam int BQ = DD2_FE + DD2_LAT * 10;

    t_dbl         w_s1h, w_s1l, w_s2h, w_s2l;
    t_dbl         w_e1, w_n1s, w_t1, w_n1l, w_e2, w_s, w_t2, w_lo;
    logic [127:0] w_q11;
    logic [191:0] w_q12, w_q13;
    logic [127:0] w_q14;
    logic [63:0]  w_q15;
    logic [127:0] w_q16, w_q17;
    logic [63:0]  w_q18;

    assign w_s1h = w_th[1][0];
    assign w_s1l = w_tl[1][0];
    assign w_s2h = w_th[1][1];
    assign w_s2l = w_tl[1][1];

    // e1 = s1.lo + s2.hi
    dd2_fadd #(.PW(128)) u_q11 (
        .i_clk(i_clk), .i_en(w_en[BQ +: DD2_LAT]),
        .i_a(w_s1l), .i_b(w_s2h), .i_pass({w_s1h, w_s2l}),
        .o_sum(w_e1), .o_pass(w_q11)
    );
    // n1 = s1.hi + e1
    dd2_fadd #(.PW(192)) u_q12 (
        .i_clk(i_clk), .i_en(w_en[BQ + DD2_LAT +: DD2_LAT]),
        .i_a(w_q11[127:64]), .i_b(w_e1), .i_pass({w_q11[127:64], w_e1, w_q11[63:0]}),
        .o_sum(w_n1s), .o_pass(w_q12)
    );
    // t = n1 - s1.hi
    dd2_fadd #(.PW(192)) u_q13 (
        .i_clk(i_clk), .i_en(w_en[BQ + 2*DD2_LAT +: DD2_LAT]),
        .i_a(w_n1s), .i_b(neg(w_q12[191:128])), .i_pass({w_n1s, w_q12[127:0]}),
        .o_sum(w_t1), .o_pass(w_q13)
    );
    // n1 correction = e1 - t
    dd2_fadd #(.PW(128)) u_q14 (
        .i_clk(i_clk), .i_en(w_en[BQ + 3*DD2_LAT +: DD2_LAT]),
        .i_a(w_q13[127:64]), .i_b(neg(w_t1)), .i_pass({w_q13[191:128], w_q13[63:0]}),
        .o_sum(w_n1l), .o_pass(w_q14)
    );
    // e2 = n1 correction + s2.lo
    dd2_fadd #(.PW(64)) u_q15 (
        .i_clk(i_clk), .i_en(w_en[BQ + 4*DD2_LAT +: DD2_LAT]),
        .i_a(w_n1l), .i_b(w_q14[63:0]), .i_pass(w_q14[127:64]),
        .o_sum(w_e2), .o_pass(w_q15)
    );
    // s = n1 + e2
    dd2_fadd #(.PW(128)) u_q16 (
        .i_clk(i_clk), .i_en(w_en[BQ + 5*DD2_LAT +: DD2_LAT]),
        .i_a(w_q15), .i_b(w_e2), .i_pass({w_q15, w_e2}),
        .o_sum(w_s), .o_pass(w_q16)
    );
    // t2 = s - n1
    dd2_fadd #(.PW(128)) u_q17 (
        .i_clk(i_clk), .i_en(w_en[BQ + 6*DD2_LAT +: DD2_LAT]),
        .i_a(w_s), .i_b(neg(w_q16[127:64])), .i_pass({w_s, w_q16[63:0]}),
        .o_sum(w_t2), .o_pass(w_q17)
    );
    // lo = e2 - t2; this adder's output register is the output stage
    dd2_fadd #(.PW(64)) u_q18 (
        .i_clk(i_clk), .i_en(w_en[BQ + 7*DD2_LAT +: DD2_LAT]),
        .i_a(w_q17[63:0]), .i_b(neg(w_t2)), .i_pass(w_q17[127:64]),
        .o_sum(w_lo), .o_pass(w_q18)
    );

    assign o_out.high_part = w_q18;
    assign o_out.low_part  = w_lo;

`ifndef ASSERT_OFF
    // input stalls only when the output transaction is blocked
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (o_out.valid && !o_out.ready))
        else $error("input stalled without a blocked output");

    // an empty output stage never stalls the input
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out.valid |-> i_in.ready)
        else $error("input stalled while output stage empty");

    // integer durations never give an infinity or a nan
    a_finite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.high_part[62:52] != 11'h7FF
                         && o_out.low_part[62:52] != 11'h7FF))
        else $error("non-finite result");

    // a zero leading word leaves no correction term
    a_zero_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.high_part[62:0] == 63'd0) |-> o_out.low_part[62:0] == 63'd0)
        else $error("nonzero correction with zero leading word");
`endif

endmodule

`default_nettype wire
